// File: rtl/clock_row_slot_allocator_defines.svh
// ----------------------------------------------------------------------------
// Clock row slot allocator assertion macros
// Concurrent assertion wrappers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CLOCK_ROW_SLOT_ALLOCATOR_DEFINES_SVH
`define CLOCK_ROW_SLOT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
`define CRSA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clock_row_slot_allocator: assertion failed");
`define CRSA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clock_row_slot_allocator: assertion failed");
`else
`define CRSA_ASSERT_IMP(label, ante, cons)
`define CRSA_ASSERT_NXT(label, ante, cons)
`endif

`endif

// File: rtl/crsa_pkg.sv
// ----------------------------------------------------------------------------
// Clock row slot allocator package
// Sequencer states, register indexes and field widths shared by the design.
// ----------------------------------------------------------------------------
package crsa_pkg;

    localparam int AGE_W    = 11;
    localparam int WRAPS_W  = 3;
    localparam int SLOT_W   = 10;
    localparam int SERIAL_W = 32;

    localparam logic [1:0] REG_FRESH_AGE      = 2'd0;
    localparam logic [1:0] REG_KEEP_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_RELEASE_AGE    = 2'd2;
    localparam logic [1:0] REG_MAX_WRAPS      = 2'd3;

    localparam logic [AGE_W-1:0]   FRESH_AGE_RST      = 11'd1000;
    localparam logic [AGE_W-1:0]   KEEP_THRESHOLD_RST = 11'd500;
    localparam logic [AGE_W-1:0]   RELEASE_AGE_RST    = 11'd2;
    localparam logic [WRAPS_W-1:0] MAX_WRAPS_RST      = 3'd3;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP,
        ST_EVAL,
        ST_DONE
    } state_t;

endpackage

// File: rtl/clock_row_slot_allocator.sv
// ----------------------------------------------------------------------------
// Clock row slot allocator
// Release: ST_DONE holds until the result stream is free, then returns to ST_IDLE.
// Allocate: each visit runs ST_STEP then ST_EVAL; one read of the slot memories per visit.
// Reset clears the in-use and age memories slot by slot while s_tready is low.
// ----------------------------------------------------------------------------
`include "clock_row_slot_allocator_defines.svh"

module clock_row_slot_allocator #(
    parameter int SLOTS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] slot_index
    input  logic        s_tuser,   // [0] op
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [9:0] granted_slot, [41:10] serial
    output logic        m_tuser    // [0] failed
);

    localparam int HAND_W = $clog2(SLOTS);
    localparam int AGE_W  = crsa_pkg::AGE_W;
    localparam int WR_W   = crsa_pkg::WRAPS_W;
    localparam int SL_W   = crsa_pkg::SLOT_W;
    localparam int SER_W  = crsa_pkg::SERIAL_W;
    localparam logic [HAND_W-1:0] LAST_SLOT = HAND_W'(SLOTS - 1);

    crsa_pkg::state_t state_reg, state_next;

    logic [AGE_W-1:0]  fresh_age_reg, keep_threshold_reg, release_age_reg;
    logic [WR_W-1:0]   max_wraps_reg;
    logic [HAND_W-1:0] hand_reg, hand_next;
    logic [HAND_W-1:0] clr_reg, clr_next;
    logic [WR_W-1:0]   wraps_reg, wraps_next;
    logic [SER_W-1:0]  serial_reg, serial_next;
    logic [SL_W-1:0]   res_slot_reg, res_slot_next;
    logic [SER_W-1:0]  res_serial_reg, res_serial_next;
    logic              res_failed_reg, res_failed_next;
    logic              m_valid_reg, m_valid_next;
    logic [SL_W-1:0]   m_slot_reg, m_slot_next;
    logic [SER_W-1:0]  m_serial_reg, m_serial_next;
    logic              m_failed_reg, m_failed_next;

    logic [AGE_W-1:0]  age_mem [SLOTS];
    logic              use_mem [SLOTS];
    logic [AGE_W-1:0]  rd_age_reg;
    logic              rd_use_reg;

    logic              age_we, use_we, rd_en;
    logic [HAND_W-1:0] waddr, raddr;
    logic [AGE_W-1:0]  wage;
    logic              wuse;

    logic              cfg_we;
    logic [HAND_W-1:0] hand_inc;
    logic              eval_take;
    logic [AGE_W-1:0]  age_dec, age_new;
    logic              search_end;
    logic              out_free;
    logic              rel_in_range;
    logic [SL_W-1:0]   req_slot;

    // Configuration registers
    assign cfg_we = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_age_reg      <= crsa_pkg::FRESH_AGE_RST;
            keep_threshold_reg <= crsa_pkg::KEEP_THRESHOLD_RST;
            release_age_reg    <= crsa_pkg::RELEASE_AGE_RST;
            max_wraps_reg      <= crsa_pkg::MAX_WRAPS_RST;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                crsa_pkg::REG_FRESH_AGE:      fresh_age_reg      <= pwdata[AGE_W-1:0];
                crsa_pkg::REG_KEEP_THRESHOLD: keep_threshold_reg <= pwdata[AGE_W-1:0];
                crsa_pkg::REG_RELEASE_AGE:    release_age_reg    <= pwdata[AGE_W-1:0];
                crsa_pkg::REG_MAX_WRAPS:      max_wraps_reg      <= pwdata[WR_W-1:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            crsa_pkg::REG_FRESH_AGE:      prdata = 32'(fresh_age_reg);
            crsa_pkg::REG_KEEP_THRESHOLD: prdata = 32'(keep_threshold_reg);
            crsa_pkg::REG_RELEASE_AGE:    prdata = 32'(release_age_reg);
            crsa_pkg::REG_MAX_WRAPS:      prdata = 32'(max_wraps_reg);
            default:                      prdata = '0;
        endcase
    end

    // Slot memories
    always_ff @(posedge clk)
    begin
        if (age_we)
        begin
            age_mem[waddr] <= wage;
        end
        if (rd_en)
        begin
            rd_age_reg <= age_mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (use_we)
        begin
            use_mem[waddr] <= wuse;
        end
        if (rd_en)
        begin
            rd_use_reg <= use_mem[raddr];
        end
    end

    // Shared datapath
    assign hand_inc     = (hand_reg == LAST_SLOT) ? '0 : hand_reg + 1'b1;
    assign eval_take    = !rd_use_reg || (rd_age_reg == '0);
    assign age_dec      = rd_age_reg - 1'b1;
    assign age_new      = (age_dec > keep_threshold_reg) ? fresh_age_reg : age_dec;
    assign search_end   = (wraps_reg >= max_wraps_reg);
    assign out_free     = !m_valid_reg || m_tready;
    assign req_slot     = s_tdata[SL_W-1:0];
    assign rel_in_range = ({7'd0, req_slot} < 17'(SLOTS));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            crsa_pkg::ST_CLEAR:
            begin
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = crsa_pkg::ST_IDLE;
                end
            end
            crsa_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (s_tuser == crsa_pkg::OP_RELEASE) ?
                                 crsa_pkg::ST_DONE : crsa_pkg::ST_STEP;
                end
            end
            crsa_pkg::ST_STEP:
            begin
                state_next = crsa_pkg::ST_EVAL;
            end
            crsa_pkg::ST_EVAL:
            begin
                if (eval_take || search_end)
                begin
                    state_next = crsa_pkg::ST_DONE;
                end
                else
                begin
                    state_next = crsa_pkg::ST_STEP;
                end
            end
            crsa_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = crsa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = crsa_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath registers
    always_comb
    begin
        s_tready        = 1'b0;
        age_we          = 1'b0;
        use_we          = 1'b0;
        rd_en           = 1'b0;
        waddr           = hand_reg;
        raddr           = hand_inc;
        wage            = '0;
        wuse            = 1'b0;
        hand_next       = hand_reg;
        clr_next        = clr_reg;
        wraps_next      = wraps_reg;
        serial_next     = serial_reg;
        res_slot_next   = res_slot_reg;
        res_serial_next = res_serial_reg;
        res_failed_next = res_failed_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_slot_next     = m_slot_reg;
        m_serial_next   = m_serial_reg;
        m_failed_next   = m_failed_reg;

        unique case (state_reg)
            crsa_pkg::ST_CLEAR:
            begin
                age_we   = 1'b1;
                use_we   = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            crsa_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    wraps_next = '0;
                    if (s_tuser == crsa_pkg::OP_RELEASE)
                    begin
                        res_slot_next   = req_slot;
                        res_serial_next = '0;
                        res_failed_next = 1'b0;
                        age_we          = rel_in_range;
                        waddr           = HAND_W'(req_slot);
                        wage            = release_age_reg;
                    end
                end
            end
            crsa_pkg::ST_STEP:
            begin
                rd_en     = 1'b1;
                hand_next = hand_inc;
                if (hand_inc == '0)
                begin
                    wraps_next = wraps_reg + 1'b1;
                end
            end
            crsa_pkg::ST_EVAL:
            begin
                age_we = 1'b1;
                if (eval_take)
                begin
                    use_we          = 1'b1;
                    wuse            = 1'b1;
                    wage            = fresh_age_reg;
                    res_slot_next   = SL_W'(hand_reg);
                    res_serial_next = serial_reg;
                    res_failed_next = 1'b0;
                    serial_next     = serial_reg + 1'b1;
                end
                else
                begin
                    wage = age_new;
                    if (search_end)
                    begin
                        res_slot_next   = '0;
                        res_serial_next = '0;
                        res_failed_next = 1'b1;
                    end
                end
            end
            crsa_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_slot_next   = res_slot_reg;
                    m_serial_next = res_serial_reg;
                    m_failed_next = res_failed_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= crsa_pkg::ST_CLEAR;
            hand_reg    <= '0;
            clr_reg     <= '0;
            wraps_reg   <= '0;
            serial_reg  <= SER_W'(1);
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            hand_reg    <= hand_next;
            clr_reg     <= clr_next;
            wraps_reg   <= wraps_next;
            serial_reg  <= serial_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_slot_reg   <= res_slot_next;
        res_serial_reg <= res_serial_next;
        res_failed_reg <= res_failed_next;
        m_slot_reg     <= m_slot_next;
        m_serial_reg   <= m_serial_next;
        m_failed_reg   <= m_failed_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_serial_reg, m_slot_reg};
    assign m_tuser  = m_failed_reg;

    `CRSA_ASSERT_IMP(a_no_accept_in_clear, state_reg == crsa_pkg::ST_CLEAR, !s_tready)
    `CRSA_ASSERT_IMP(a_failed_is_empty, m_tvalid && m_tuser, m_tdata[41:0] == 42'd0)
    `CRSA_ASSERT_NXT(a_hand_steps_once, state_reg == crsa_pkg::ST_STEP, hand_reg == $past(hand_inc))

endmodule
